// ===== rtl/core/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Bracket syntax checker package
// Shared constants, codes, types and helper functions of the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsc_pkg;

  // Stack geometry.
  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Field widths of the channels.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LINE_W   = 24;
  localparam int unsigned DEPTH_W  = 7;
  localparam int unsigned CODE_W   = 2;
  localparam int unsigned STATUS_W = 3;

  localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
  localparam logic [LINE_W-1:0] LINE_ONE = LINE_W'(1);

  // Characters of interest.
  localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [BYTE_W-1:0] CH_LSQUARE = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RSQUARE = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_STAR = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;

  // Bracket codes as kept on the stack.
  localparam logic [CODE_W-1:0] BR_NONE   = 2'd0;
  localparam logic [CODE_W-1:0] BR_PAREN  = 2'd1;
  localparam logic [CODE_W-1:0] BR_SQUARE = 2'd2;
  localparam logic [CODE_W-1:0] BR_BRACE  = 2'd3;

  // Item kinds.
  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_RUNNING   = 3'd0,
    ST_MISMATCH  = 3'd1,
    ST_PASSED    = 3'd2,
    ST_UNTERM    = 3'd3,
    ST_UNMATCHED = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_e;

  // Stack operation requested by the scanner.
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [CODE_W-1:0] code;
  } stk_op_t;

  // Error events reported by the stack controller.
  typedef struct packed {
    logic              overflow;
    logic              mismatch;
    logic [CODE_W-1:0] opener;
  } stk_evt_t;

  function automatic logic [CODE_W-1:0] opener_code(input logic [BYTE_W-1:0] c);
    logic [CODE_W-1:0] r;
    r = BR_NONE;
    if (c == CH_LPAREN) r = BR_PAREN;
    if (c == CH_LSQUARE) r = BR_SQUARE;
    if (c == CH_LBRACE) r = BR_BRACE;
    return r;
  endfunction

  function automatic logic [CODE_W-1:0] closer_code(input logic [BYTE_W-1:0] c);
    logic [CODE_W-1:0] r;
    r = BR_NONE;
    if (c == CH_RPAREN) r = BR_PAREN;
    if (c == CH_RSQUARE) r = BR_SQUARE;
    if (c == CH_RBRACE) r = BR_BRACE;
    return r;
  endfunction

endpackage

// ===== rtl/core/bsc_in_if.sv =====
// ----------------------------------------------------------------------------
// Bracket syntax checker input channel
// Valid/ready channel that carries one text byte or an end marker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bsc_in_if import bsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] text_byte;

  modport source (output valid, output kind, output text_byte, input ready);
  modport sink   (input valid, input kind, input text_byte, output ready);
endinterface

// ===== rtl/core/bsc_out_if.sv =====
// ----------------------------------------------------------------------------
// Bracket syntax checker output channel
// Valid/ready channel that carries one checker result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bsc_out_if import bsc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [LINE_W-1:0]   line_number;
  logic [DEPTH_W-1:0]  open_depth;
  logic [CODE_W-1:0]   opener_seen;
  logic [CODE_W-1:0]   closer_seen;

  modport source (output valid, output status, output line_number, output open_depth,
                  output opener_seen, output closer_seen, input ready);
  modport sink   (input valid, input status, input line_number, input open_depth,
                  input opener_seen, input closer_seen, output ready);
endinterface

// ===== rtl/core/bsc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsc_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/bsc_scan.sv =====
// ----------------------------------------------------------------------------
// Bracket syntax checker scanner
// Lexical mode flags, line counter and bracket operation decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsc_scan import bsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [BYTE_W-1:0] byte_i,
  output stk_op_t           op_o,
  output logic              quote_open_o,
  output logic [LINE_W-1:0] line_o
);

  logic              esc_q, esc_d;
  logic              str_q, str_d;
  logic              chr_q, chr_d;
  logic              cmt_q, cmt_d;
  logic              sls_q, sls_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic              bracket_ok;

  always_comb begin
    esc_d      = esc_q;
    str_d      = str_q;
    chr_d      = chr_q;
    cmt_d      = cmt_q;
    sls_d      = sls_q;
    line_d     = line_q;
    bracket_ok = 1'b0;

    if (byte_i == CH_NEWLINE && line_q != LINE_MAX) begin
      line_d = line_q + LINE_ONE;
    end

    if (esc_q) begin
      esc_d = 1'b0;
      sls_d = 1'b0;
    end else if (byte_i == CH_BACKSLASH) begin
      esc_d = 1'b1;
      sls_d = 1'b0;
    end else if (str_q) begin
      if (byte_i == CH_DQUOTE) str_d = 1'b0;
    end else if (chr_q) begin
      if (byte_i == CH_SQUOTE) chr_d = 1'b0;
    end else if (cmt_q) begin
      if (byte_i == CH_STAR) begin
        sls_d = 1'b1;
      end else if (byte_i == CH_SLASH && sls_q) begin
        cmt_d = 1'b0;
        sls_d = 1'b0;
      end else begin
        sls_d = 1'b0;
      end
    end else if (byte_i == CH_STAR && sls_q) begin
      cmt_d = 1'b1;
      sls_d = 1'b0;
    end else if (byte_i == CH_SLASH) begin
      sls_d = 1'b1;
    end else begin
      sls_d = 1'b0;
      if (byte_i == CH_DQUOTE) begin
        str_d = 1'b1;
      end else if (byte_i == CH_SQUOTE) begin
        chr_d = 1'b1;
      end else begin
        bracket_ok = 1'b1;
      end
    end
  end

  assign op_o.push = bracket_ok && (opener_code(byte_i) != BR_NONE);
  assign op_o.pop  = bracket_ok && (closer_code(byte_i) != BR_NONE);
  assign op_o.code = opener_code(byte_i) | closer_code(byte_i);

  assign quote_open_o = str_q | chr_q;
  assign line_o       = en_i ? line_d : line_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q  <= 1'b0;
      str_q  <= 1'b0;
      chr_q  <= 1'b0;
      cmt_q  <= 1'b0;
      sls_q  <= 1'b0;
      line_q <= LINE_ONE;
    end else if (en_i) begin
      esc_q  <= esc_d;
      str_q  <= str_d;
      chr_q  <= chr_d;
      cmt_q  <= cmt_d;
      sls_q  <= sls_d;
      line_q <= line_d;
    end
  end

endmodule

// ===== rtl/core/bsc_stack.sv =====
// ----------------------------------------------------------------------------
// Bracket syntax checker stack controller
// Bracket stack in RAM with the top entry held in a register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsc_stack import bsc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  stk_op_t            op_i,
  output stk_evt_t           evt_o,
  output logic               empty_o,
  output logic [DEPTH_W-1:0] depth_o
);

  logic [SP_W-1:0]   sp_q, sp_d;
  logic [CODE_W-1:0] top_q, top_d;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [CODE_W-1:0] rdata;

  // The RAM always reads the entry just below the next top, so a pop in the
  // following cycle finds the new top in rdata.
  always_comb begin
    sp_d  = sp_q;
    top_d = top_q;
    we    = 1'b0;
    waddr = sp_q[ADDR_W-1:0];
    evt_o = '0;

    if (en_i && op_i.push) begin
      if (sp_q == SP_W'(STACK_DEPTH)) begin
        evt_o.overflow = 1'b1;
      end else begin
        we    = 1'b1;
        top_d = op_i.code;
        sp_d  = sp_q + SP_W'(1);
      end
    end else if (en_i && op_i.pop) begin
      if (sp_q == '0) begin
        evt_o.mismatch = 1'b1;
        evt_o.opener   = BR_NONE;
      end else begin
        sp_d  = sp_q - SP_W'(1);
        top_d = rdata;
        if (top_q != op_i.code) begin
          evt_o.mismatch = 1'b1;
          evt_o.opener   = top_q;
        end
      end
    end

    if (sp_d >= SP_W'(2)) begin
      raddr = ADDR_W'(sp_d - SP_W'(2));
    end else begin
      raddr = '0;
    end
  end

  bsc_ram #(
    .WIDTH(CODE_W),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(op_i.code),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else begin
      sp_q <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

  assign empty_o = (sp_q == '0);
  assign depth_o = DEPTH_W'(sp_d);

  // The stack pointer never passes the stack depth.
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  // The stack pointer moves only on an accepted byte.
  a_sp_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(sp_q))
    else $error("stack pointer moved without an accepted byte");

  // A push onto a full stack leaves the stack as it was.
  a_full_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && op_i.push && sp_q == SP_W'(STACK_DEPTH)) |=> $stable(sp_q))
    else $error("push onto a full stack moved the pointer");

endmodule

// ===== rtl/core/bracket_syntax_checker_top.sv =====
// ----------------------------------------------------------------------------
// Bracket syntax checker top level
// Result: registered, valid in the cycle after its input transaction.
// Throughput: one transaction per cycle unless the receiver stalls, limited by
// the single stack RAM port pair (one write and one read) and registered top.
// Reset (rst_ni, asynchronous, active low) clears the mode flags, the stack
// pointer and the latched status and sets the line counter to one; the
// stack RAM is not cleared, and items are accepted right after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bracket_syntax_checker_top import bsc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bsc_in_if.sink    in_i,
  bsc_out_if.source out_o
);

  // Handshake. A single output register separates the two channels: a new
  // input transaction is taken whenever that register is empty or is being
  // drained in the same cycle.
  logic accept;
  logic out_valid_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // Status latch. Once the status leaves running, every later transaction
  // repeats it unchanged until reset.
  status_e           status_q, status_d;
  logic [CODE_W-1:0] err_open_q, err_open_d;
  logic [CODE_W-1:0] err_close_q, err_close_d;
  logic              running;
  logic              byte_en;
  logic              end_en;

  assign running = (status_q == ST_RUNNING);
  assign byte_en = accept && running && (in_i.kind == KIND_TEXT);
  assign end_en  = accept && running && (in_i.kind == KIND_END);

  // Scanner: quotes, comments, escapes and the line count.
  stk_op_t           op;
  logic              quote_open;
  logic [LINE_W-1:0] line_next;

  bsc_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (byte_en),
    .byte_i      (in_i.text_byte),
    .op_o        (op),
    .quote_open_o(quote_open),
    .line_o      (line_next)
  );

  // Stack controller: pushes openers and checks closers against the top.
  stk_evt_t           evt;
  logic               stack_empty;
  logic [DEPTH_W-1:0] depth_next;

  bsc_stack u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (byte_en),
    .op_i   (op),
    .evt_o  (evt),
    .empty_o(stack_empty),
    .depth_o(depth_next)
  );

  // The verdict at the end marker looks at quotes first, then at the stack.
  // An open block comment at the end is not an error.
  always_comb begin
    status_d    = status_q;
    err_open_d  = err_open_q;
    err_close_d = err_close_q;
    if (end_en) begin
      if (quote_open) begin
        status_d = ST_UNTERM;
      end else if (stack_empty) begin
        status_d = ST_PASSED;
      end else begin
        status_d = ST_UNMATCHED;
      end
    end else if (byte_en && evt.overflow) begin
      status_d = ST_OVERFLOW;
    end else if (byte_en && evt.mismatch) begin
      status_d    = ST_MISMATCH;
      err_open_d  = evt.opener;
      err_close_d = op.code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q    <= ST_RUNNING;
      err_open_q  <= BR_NONE;
      err_close_q <= BR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      status_q    <= status_d;
      err_open_q  <= err_open_d;
      err_close_q <= err_close_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register. The mismatch codes are shown only with a mismatch.
  logic [STATUS_W-1:0] res_status_q;
  logic [LINE_W-1:0]   res_line_q;
  logic [DEPTH_W-1:0]  res_depth_q;
  logic [CODE_W-1:0]   res_open_q;
  logic [CODE_W-1:0]   res_close_q;
  logic                is_mismatch;

  assign is_mismatch = (status_d == ST_MISMATCH);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_status_q <= status_d;
      res_line_q   <= line_next;
      res_depth_q  <= depth_next;
      res_open_q   <= is_mismatch ? err_open_d : BR_NONE;
      res_close_q  <= is_mismatch ? err_close_d : BR_NONE;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = res_status_q;
  assign out_o.line_number = res_line_q;
  assign out_o.open_depth  = res_depth_q;
  assign out_o.opener_seen = res_open_q;
  assign out_o.closer_seen = res_close_q;

  // A latched status never changes again.
  a_status_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_q != ST_RUNNING) |=> $stable(status_q))
    else $error("latched status changed");

  // Every accepted transaction leaves a result in the output register.
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted transaction produced no result");

  // A mismatch always names the offending closer.
  a_mismatch_closer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_status_q == ST_MISMATCH) |-> (res_close_q != BR_NONE))
    else $error("mismatch result without a closer code");

  // The line count never reads zero.
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_line_q != '0))
    else $error("line number zero in a result");

endmodule

// ===== tb/bracket_syntax_checker_top_test.sv =====
// ----------------------------------------------------------------------------
// Bracket syntax checker top level testbench
// Streams C-like source text through the checker and compares every result
// with a cycle-free scanner model kept in the testbench. A short directed
// sequence opens the run. Random, mostly well-formed text follows, and one
// terminating event closes it. Idling on both channels changes by phase, and
// the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bracket_syntax_checker_top_test;
  import bsc_pkg::*;

  localparam int unsigned RANDOM_ITEMS     = 1200;
  localparam int unsigned GOAL_SPAN        = 250;
  localparam int unsigned PHASE_SPAN       = 150;
  localparam int unsigned HOLD_OFF_AT      = 600;
  localparam int unsigned HOLD_OFF_CYCLES  = 60;
  localparam int unsigned WATCHDOG_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES     = 10;
  localparam int unsigned MAX_SHOWN_ERRORS = 40;
  localparam int unsigned TRAILING_ITEMS   = 8;

  // A harmless letter, used wherever a byte must not disturb the scanner.
  localparam logic [BYTE_W-1:0] CH_FILLER = 8'h61;

  // How the text stream is finally terminated.
  typedef enum int unsigned {
    END_MISMATCH,
    END_EMPTY_CLOSER,
    END_OVERFLOW,
    END_PASSED,
    END_UNTERM,
    END_UNMATCHED
  } ending_e;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] text;
  } text_item_t;

  // Full scanner state. The bracket stack is packed, two bits per entry.
  typedef struct packed {
    logic                     esc;
    logic                     in_str;
    logic                     in_chr;
    logic                     in_cmt;
    logic                     slash_star;
    logic [SP_W-1:0]          sp;
    logic [LINE_W-1:0]        line;
    status_e                  status;
    logic [CODE_W-1:0]        err_open;
    logic [CODE_W-1:0]        err_close;
    logic [CODE_W*STACK_DEPTH-1:0] stack;
  } scan_state_t;

  typedef struct packed {
    status_e            status;
    logic [LINE_W-1:0]  line;
    logic [DEPTH_W-1:0] depth;
    logic [CODE_W-1:0]  opener;
    logic [CODE_W-1:0]  closer;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bsc_in_if  text_ch ();
  bsc_out_if verdict_ch ();

  bracket_syntax_checker_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (text_ch),
    .out_o  (verdict_ch)
  );

  always #6 clk_i = ~clk_i;

  // Items waiting to be offered, and the results that the accepted items owe.
  text_item_t  pending_text[$];
  verdict_t    expected_verdicts[$];

  // The scanner as seen by the checking side, advanced per accepted item.
  scan_state_t scan_model;
  // A second scanner, advanced while the stimulus is planned, so that the
  // generator knows which mode the block will be in at every byte.
  scan_state_t plan_model;

  int unsigned items_in;
  int unsigned mismatch_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_left;
  logic        hold_off_done;
  int unsigned quiet_cycles;
  int unsigned depth_goal;

  // --------------------------------------------------------------------------
  // Scanner model
  // --------------------------------------------------------------------------

  function automatic scan_state_t reset_scan_state();
    scan_state_t s;
    s        = '0;
    s.line   = LINE_ONE;
    s.status = ST_RUNNING;
    return s;
  endfunction

  // Code of the bracket on top of the stack; only called with a non-empty stack.
  function automatic logic [CODE_W-1:0] top_code(scan_state_t s);
    int unsigned slot;
    slot = 32'(s.sp);
    return s.stack[CODE_W*(slot-1) +: CODE_W];
  endfunction

  function automatic scan_state_t next_scan_state(scan_state_t s, logic kind,
                                                  logic [BYTE_W-1:0] c);
    scan_state_t       n;
    logic [CODE_W-1:0] oc;
    logic [CODE_W-1:0] cc;
    logic [CODE_W-1:0] top;
    int unsigned       slot;
    n    = s;
    slot = 32'(s.sp);
    oc   = BR_NONE;
    cc   = BR_NONE;
    case (c)
      CH_LPAREN:  oc = BR_PAREN;
      CH_LSQUARE: oc = BR_SQUARE;
      CH_LBRACE:  oc = BR_BRACE;
      CH_RPAREN:  cc = BR_PAREN;
      CH_RSQUARE: cc = BR_SQUARE;
      CH_RBRACE:  cc = BR_BRACE;
      default: ;
    endcase
    // Once any status is latched, nothing moves until reset.
    if (s.status != ST_RUNNING) return n;
    if (kind == KIND_END) begin
      if (s.in_str || s.in_chr) n.status = ST_UNTERM;
      else if (s.sp == 0) n.status = ST_PASSED;
      else n.status = ST_UNMATCHED;
      return n;
    end
    // A newline counts whatever mode the scanner is in.
    if (c == CH_NEWLINE && s.line != LINE_MAX) n.line = s.line + 1'b1;
    if (s.esc) begin
      n.esc        = 1'b0;
      n.slash_star = 1'b0;
    end else if (c == CH_BACKSLASH) begin
      n.esc        = 1'b1;
      n.slash_star = 1'b0;
    end else if (s.in_str) begin
      if (c == CH_DQUOTE) n.in_str = 1'b0;
    end else if (s.in_chr) begin
      if (c == CH_SQUOTE) n.in_chr = 1'b0;
    end else if (s.in_cmt) begin
      if (c == CH_STAR) begin
        n.slash_star = 1'b1;
      end else if (c == CH_SLASH && s.slash_star) begin
        n.in_cmt     = 1'b0;
        n.slash_star = 1'b0;
      end else begin
        n.slash_star = 1'b0;
      end
    end else if (c == CH_STAR && s.slash_star) begin
      n.in_cmt     = 1'b1;
      n.slash_star = 1'b0;
    end else if (c == CH_SLASH) begin
      n.slash_star = 1'b1;
    end else begin
      n.slash_star = 1'b0;
      if (c == CH_DQUOTE) begin
        n.in_str = 1'b1;
      end else if (c == CH_SQUOTE) begin
        n.in_chr = 1'b1;
      end else if (oc != BR_NONE) begin
        if (slot == STACK_DEPTH) begin
          n.status = ST_OVERFLOW;
        end else begin
          n.stack[CODE_W*slot +: CODE_W] = oc;
          n.sp = s.sp + 1'b1;
        end
      end else if (cc != BR_NONE) begin
        if (slot == 0) begin
          n.status    = ST_MISMATCH;
          n.err_open  = BR_NONE;
          n.err_close = cc;
        end else begin
          top  = top_code(s);
          n.sp = s.sp - 1'b1;
          if (top != cc) begin
            n.status    = ST_MISMATCH;
            n.err_open  = top;
            n.err_close = cc;
          end
        end
      end
    end
    return n;
  endfunction

  function automatic verdict_t verdict_of(scan_state_t s);
    verdict_t v;
    v.status = s.status;
    v.line   = s.line;
    v.depth  = DEPTH_W'(s.sp);
    v.opener = (s.status == ST_MISMATCH) ? s.err_open : BR_NONE;
    v.closer = (s.status == ST_MISMATCH) ? s.err_close : BR_NONE;
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus planning
  // --------------------------------------------------------------------------

  function automatic logic [BYTE_W-1:0] bracket_char(logic [CODE_W-1:0] code,
                                                     logic opening);
    case (code)
      BR_PAREN:  return opening ? CH_LPAREN : CH_RPAREN;
      BR_SQUARE: return opening ? CH_LSQUARE : CH_RSQUARE;
      default:   return opening ? CH_LBRACE : CH_RBRACE;
    endcase
  endfunction

  task automatic queue_item(logic kind, logic [BYTE_W-1:0] c);
    text_item_t item;
    item.kind = kind;
    item.text = c;
    pending_text.push_back(item);
    plan_model = next_scan_state(plan_model, kind, c);
  endtask

  task automatic queue_text(logic [BYTE_W-1:0] c);
    queue_item(KIND_TEXT, c);
  endtask

  task automatic queue_opener();
    queue_text(bracket_char(CODE_W'($urandom_range(BR_PAREN, BR_BRACE)), 1'b1));
  endtask

  // One random byte that fits the mode the scanner will be in. Bytes that
  // would latch an error this early are swapped for a plain letter, so that
  // the bulk of the run stays in the running state.
  task automatic queue_random_text();
    logic [BYTE_W-1:0] c;
    int unsigned       pick;
    logic              opening;
    scan_state_t       trial;
    c = BYTE_W'($urandom_range(0, 255));
    if (plan_model.esc) begin
      // Anything goes after a backslash.
    end else if (plan_model.in_str) begin
      if ($urandom_range(0, 5) == 0) c = CH_DQUOTE;
    end else if (plan_model.in_chr) begin
      if ($urandom_range(0, 1) == 0) c = CH_SQUOTE;
    end else if (plan_model.in_cmt) begin
      if (plan_model.slash_star && $urandom_range(0, 1) == 0) c = CH_SLASH;
      else if ($urandom_range(0, 3) == 0) c = CH_STAR;
    end else if (plan_model.slash_star && $urandom_range(0, 1) == 0) begin
      c = CH_STAR;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // Walk the nesting depth toward the current goal.
        if (plan_model.sp == 0) opening = 1'b1;
        else if (plan_model.sp < depth_goal) opening = ($urandom_range(0, 7) != 0);
        else opening = ($urandom_range(0, 7) == 0);
        c = opening ? bracket_char(CODE_W'($urandom_range(BR_PAREN, BR_BRACE)), 1'b1)
                    : bracket_char(top_code(plan_model), 1'b0);
      end else if (pick < 45) c = CH_DQUOTE;
      else if (pick < 50) c = CH_SQUOTE;
      else if (pick < 57) c = CH_SLASH;
      else if (pick < 62) c = CH_STAR;
      else if (pick < 66) c = CH_BACKSLASH;
      else if (pick < 74) c = CH_NEWLINE;
      // The rest stays a fully random byte.
    end
    trial = next_scan_state(plan_model, KIND_TEXT, c);
    if (trial.status != ST_RUNNING) c = CH_FILLER;
    queue_text(c);
  endtask

  // Leave escapes, literals and comments so that brackets count again.
  task automatic queue_settle();
    while (plan_model.esc || plan_model.in_str || plan_model.in_chr || plan_model.in_cmt) begin
      if (plan_model.esc) queue_text(CH_FILLER);
      else if (plan_model.in_str) queue_text(CH_DQUOTE);
      else if (plan_model.in_chr) queue_text(CH_SQUOTE);
      else if (plan_model.slash_star) queue_text(CH_SLASH);
      else queue_text(CH_STAR);
    end
  endtask

  task automatic queue_close_all();
    while (plan_model.sp != 0) queue_text(bracket_char(top_code(plan_model), 1'b0));
  endtask

  task automatic queue_ending(ending_e ending);
    logic [CODE_W-1:0] open_code;
    logic [CODE_W-1:0] close_code;
    queue_settle();
    case (ending)
      END_MISMATCH: begin
        open_code = CODE_W'($urandom_range(BR_PAREN, BR_BRACE));
        do close_code = CODE_W'($urandom_range(BR_PAREN, BR_BRACE));
        while (close_code == open_code);
        queue_text(bracket_char(open_code, 1'b1));
        queue_text(bracket_char(close_code, 1'b0));
      end
      END_EMPTY_CLOSER: begin
        queue_close_all();
        queue_text(bracket_char(CODE_W'($urandom_range(BR_PAREN, BR_BRACE)), 1'b0));
      end
      END_OVERFLOW: begin
        while (plan_model.sp != STACK_DEPTH) queue_opener();
        queue_opener();
      end
      END_PASSED: begin
        queue_close_all();
        // A comment still open at the end does not spoil the verdict.
        if ($urandom_range(0, 1) == 0) begin
          queue_text(CH_SLASH);
          queue_text(CH_STAR);
          queue_text(BYTE_W'($urandom_range(0, 255)));
        end
        queue_item(KIND_END, BYTE_W'($urandom_range(0, 255)));
      end
      END_UNTERM: begin
        queue_text(($urandom_range(0, 1) == 0) ? CH_DQUOTE : CH_SQUOTE);
        queue_text(CH_FILLER);
        queue_item(KIND_END, BYTE_W'($urandom_range(0, 255)));
      end
      default: begin
        queue_opener();
        queue_item(KIND_END, BYTE_W'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatch_count < MAX_SHOWN_ERRORS)
      $display("ERROR: %t %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Idling levels per phase of the run: none, sender idle, receiver stalling,
  // and both together.
  always @* begin
    case ((items_in / PHASE_SPAN) % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
      default: begin send_idle_pct = 30; recv_stall_pct = 30; end
    endcase
  end

  // Driver. Each accepted transaction advances the scanner model and queues
  // the result it owes. A valid item is held until the block takes it, and
  // while nothing is offered the payload carries random junk.
  always @(posedge clk_i) begin
    text_item_t next_item;
    logic       offer;
    if (!rst_ni) begin
      text_ch.valid <= 1'b0;
      scan_model    = reset_scan_state();
    end else begin
      if (text_ch.valid && text_ch.ready) begin
        scan_model = next_scan_state(scan_model, text_ch.kind, text_ch.text_byte);
        expected_verdicts.push_back(verdict_of(scan_model));
        items_in <= items_in + 1;
      end
      if (!text_ch.valid || text_ch.ready) begin
        // The sender never idles while the receiver holds off, so the block
        // is forced to fill up and push back on its input.
        offer = (pending_text.size() != 0) &&
                (hold_off_left != 0 || $urandom_range(0, 99) >= send_idle_pct);
        if (offer) begin
          next_item = pending_text.pop_front();
          text_ch.valid     <= 1'b1;
          text_ch.kind      <= next_item.kind;
          text_ch.text_byte <= next_item.text;
        end else begin
          text_ch.valid     <= 1'b0;
          text_ch.kind      <= 1'($urandom_range(0, 1));
          text_ch.text_byte <= BYTE_W'($urandom_range(0, 255));
        end
      end
    end
  end

  // Long hold-off of the receiver, counted down once the run is well under way.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_off_left != 0) begin
        hold_off_left <= hold_off_left - 1;
      end else if (!hold_off_done && items_in >= HOLD_OFF_AT) begin
        hold_off_done <= 1'b1;
        hold_off_left <= HOLD_OFF_CYCLES;
      end
    end
  end

  // Monitor. Every accepted result is matched against the oldest expectation.
  // The receiver's ready follows the phase, apart from one long hold-off.
  always @(posedge clk_i) begin
    verdict_t want;
    if (!rst_ni) begin
      verdict_ch.ready <= 1'b0;
    end else begin
      if (verdict_ch.valid && verdict_ch.ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("result with no transaction waiting, status",
                          32'(verdict_ch.status), 0);
        end else begin
          want = expected_verdicts.pop_front();
          if (verdict_ch.status !== want.status)
            report_mismatch("status", 32'(verdict_ch.status), 32'(want.status));
          if (verdict_ch.line_number !== want.line)
            report_mismatch("line_number", 32'(verdict_ch.line_number), 32'(want.line));
          if (verdict_ch.open_depth !== want.depth)
            report_mismatch("open_depth", 32'(verdict_ch.open_depth), 32'(want.depth));
          if (verdict_ch.opener_seen !== want.opener)
            report_mismatch("opener_seen", 32'(verdict_ch.opener_seen), 32'(want.opener));
          if (verdict_ch.closer_seen !== want.closer)
            report_mismatch("closer_seen", 32'(verdict_ch.closer_seen), 32'(want.closer));
        end
      end
      if (hold_off_left != 0) begin
        verdict_ch.ready <= 1'b0;
      end else begin
        verdict_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: too many cycles in a row without a transaction on either side
  // means the block has hung.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((text_ch.valid && text_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** bracket_syntax_checker_top: FAILED **");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    text_ch.valid     = 1'b0;
    text_ch.kind      = KIND_TEXT;
    text_ch.text_byte = '0;
    verdict_ch.ready  = 1'b0;
    rst_ni            = 1'b0;
    items_in          = 0;
    mismatch_count    = 0;
    hold_off_left     = 0;
    hold_off_done     = 1'b0;
    quiet_cycles      = 0;
    plan_model        = reset_scan_state();
    scan_model        = reset_scan_state();

    // Directed opening. Extreme byte values first.
    queue_text(8'h00);
    queue_text(8'hFF);
    // Every bracket pushed and popped in matching order.
    queue_text(CH_LPAREN);
    queue_text(CH_LSQUARE);
    queue_text(CH_LBRACE);
    queue_text(CH_RBRACE);
    queue_text(CH_RSQUARE);
    queue_text(CH_RPAREN);
    // Slash-star-slash opens a comment and does not close it again; the
    // following star-slash does.
    queue_text(CH_SLASH);
    queue_text(CH_STAR);
    queue_text(CH_SLASH);
    queue_text(CH_STAR);
    queue_text(CH_SLASH);
    // Star-slash-star outside a comment: the slash-star pair opens one.
    queue_text(CH_STAR);
    queue_text(CH_SLASH);
    queue_text(CH_STAR);
    queue_text(CH_STAR);
    queue_text(CH_SLASH);
    // An escaped newline is consumed but still counts a line.
    queue_text(CH_BACKSLASH);
    queue_text(CH_NEWLINE);
    // A closer inside a string and an escaped quote do nothing.
    queue_text(CH_DQUOTE);
    queue_text(CH_RPAREN);
    queue_text(CH_BACKSLASH);
    queue_text(CH_DQUOTE);
    queue_text(CH_DQUOTE);
    // A bracket inside a character literal is ignored.
    queue_text(CH_SQUOTE);
    queue_text(CH_LBRACE);
    queue_text(CH_SQUOTE);

    // Random text, mostly well formed, with the nesting goal changing now and
    // then so that both shallow and full stacks are visited.
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % GOAL_SPAN == 0) begin
        case ($urandom_range(0, 3))
          0: depth_goal = 1;
          1: depth_goal = 4;
          2: depth_goal = 16;
          default: depth_goal = STACK_DEPTH;
        endcase
      end
      queue_random_text();
    end

    // One terminating event, then items that must all repeat the latched
    // status, an end transaction among them.
    queue_ending(ending_e'($urandom_range(END_MISMATCH, END_UNMATCHED)));
    for (int unsigned n = 0; n < TRAILING_ITEMS; n++)
      queue_item(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)));
    queue_item(KIND_END, BYTE_W'($urandom_range(0, 255)));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait until every item is taken and every result has come back, then
    // keep the clock running through a drain period so any stray result shows.
    while (pending_text.size() != 0 || text_ch.valid || expected_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("** bracket_syntax_checker_top: PASSED **");
    end else begin
      $display("** bracket_syntax_checker_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bsc_pkg.sv
rtl/core/bsc_in_if.sv
rtl/core/bsc_out_if.sv
rtl/core/bsc_ram.sv
rtl/core/bsc_scan.sv
rtl/core/bsc_stack.sv
rtl/core/bracket_syntax_checker_top.sv
tb/bracket_syntax_checker_top_test.sv
